@@ rtl/swsc_pkg.sv @@
// ----------------------------------------------------------------------------
// swsc_pkg
// Shared constants and types for the go-back-N sender window control.
// ----------------------------------------------------------------------------
package swsc_pkg;

   // window size in packets
   localparam int unsigned WINDOW       = 5;
   // consecutive failures that abort a transfer
   localparam int unsigned MAX_FAILURES = 3;

   localparam int unsigned ID_W   = 16;
   localparam int unsigned ACK_W  = 18;
   localparam int unsigned CMD_W  = 2;
   localparam int unsigned STAT_W = 3;

   // commands
   localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

   // acknowledgement meaning "transfer finished"
   localparam logic signed [ACK_W-1:0] ACK_DONE = -18'sd1;

   // result status codes
   localparam logic [STAT_W-1:0] ST_SEND  = 3'd0;
   localparam logic [STAT_W-1:0] ST_WAIT  = 3'd1;
   localparam logic [STAT_W-1:0] ST_DONE  = 3'd2;
   localparam logic [STAT_W-1:0] ST_ABORT = 3'd3;
   localparam logic [STAT_W-1:0] ST_IDLE  = 3'd4;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   packet_id;
      logic              last;
   } rsp_item_type;

endpackage

@@ rtl/sliding_window_sender_control.sv @@
// ----------------------------------------------------------------------------
// sliding_window_sender_control
// Sender-side window control of a go-back-N transfer of packets 1..total.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  -----------------------------------
//  req      in   req_tvalid/req_tready  tuser: command, tdata: ack_value
//  rsp      out  rsp_tvalid/rsp_tready  tuser: status, tdata: packet_id,
//                                       tlast: last result of a request
//  csr      in   csr_we                 csr_wdata: total_packets
//
//  Sequence: IDLE takes a request and CHECK classifies it; on start and
//  accepted acks LOAD makes the refill steps (ids loaded plus one
//  terminating check, at most WINDOW + 1), then 1..WINDOW results go out.
//  Refill steps one id per cycle, emission one per cycle while the output
//  register is free; both use the one shared 16-bit incrementer.
//  Reset: synchronous, active high; clears the window, counters, running
//  flag and total_packets. No clearing pass.
//  Stalls: req_tready is high only while the sequencer is idle; a held
//  result in the output register stalls emission but not acceptance.
//
module sliding_window_sender_control (
   input  logic        clock,
   input  logic        reset,
   // request transactions
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [17:0] ack_value (signed), rest zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   // result transactions
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] packet_id
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast,   // last result of the request
   // configuration
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // total_packets
);
   import swsc_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0; // waiting for a request
   localparam logic [2:0] S_CHECK  = 3'd1; // classify the registered request
   localparam logic [2:0] S_LOAD   = 3'd2; // refill the window, one id a cycle
   localparam logic [2:0] S_EMIT   = 3'd3; // send ids base..loaded
   localparam logic [2:0] S_SINGLE = 3'd4; // one status-only result

   logic [2:0]              state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [ACK_W-1:0] ack_ff, ack_in;
   logic [ID_W-1:0]         total_ff, total_in;
   logic [ID_W-1:0]         base_ff, base_in;
   logic                    empty_ff, empty_in;
   logic [ID_W-1:0]         loaded_ff, loaded_in;
   logic [1:0]              retry_ff, retry_in;
   logic                    running_ff, running_in;
   logic [ID_W-1:0]         cursor_ff, cursor_in;
   logic [STAT_W-1:0]       single_ff, single_in;

   // shared incrementer: loaded in CHECK/LOAD, cursor in EMIT
   logic [ID_W-1:0]         inc_src;
   logic [ID_W:0]           inc_sum;

   logic                    push_valid;
   rsp_item_type            push_item;
   logic                    out_free;

   // CHECK terms
   logic [ID_W:0]           max_id;
   logic signed [ACK_W-1:0] max_s, lo_s, loaded_s, base_s;
   logic                    fail;

   // LOAD terms
   logic [ID_W-1:0]         span;
   logic                    full;

   assign inc_src = (state_ff == S_EMIT) ? cursor_ff : loaded_ff;
   assign inc_sum = {1'b0, inc_src} + 17'd1;

   // highest acceptable id and lower bound
   assign max_id   = (loaded_ff >= total_ff) ? {1'b0, loaded_ff} : inc_sum;
   assign max_s    = {1'b0, max_id};
   assign lo_s     = empty_ff ? '0 : {2'b00, base_ff};
   assign loaded_s = {2'b00, loaded_ff};
   assign base_s   = {2'b00, base_ff};
   assign fail     = (cmd_ff == CMD_TIMEOUT) || (ack_ff > max_s) || (ack_ff < lo_s);

   // held = span + 1; window full once held reaches WINDOW
   assign span = loaded_ff - base_ff;
   assign full = !empty_ff && (span >= ID_W'(WINDOW - 1));

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      ack_in     = ack_ff;
      total_in   = csr_we ? csr_wdata : total_ff;
      base_in    = base_ff;
      empty_in   = empty_ff;
      loaded_in  = loaded_ff;
      retry_in   = retry_ff;
      running_in = running_ff;
      cursor_in  = cursor_ff;
      single_in  = single_ff;
      push_valid = 1'b0;
      push_item  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               ack_in   = req_tdata[ACK_W-1:0];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (cmd_ff == CMD_START) begin
               base_in    = '0;
               empty_in   = 1'b1;
               loaded_in  = '0;
               retry_in   = '0;
               running_in = 1'b1;
               state_in   = S_LOAD;
            end else if (((cmd_ff != CMD_ACK) && (cmd_ff != CMD_TIMEOUT)) || !running_ff) begin
               single_in = ST_IDLE;
               state_in  = S_SINGLE;
            end else if ((cmd_ff == CMD_ACK) && (ack_ff == ACK_DONE)) begin
               running_in = 1'b0;
               retry_in   = '0;
               single_in  = ST_DONE;
               state_in   = S_SINGLE;
            end else if (fail) begin
               if (retry_ff >= 2'(MAX_FAILURES - 1)) begin
                  running_in = 1'b0;
                  retry_in   = '0;
                  single_in  = ST_ABORT;
                  state_in   = S_SINGLE;
               end else begin
                  retry_in = retry_ff + 2'd1;
                  if (empty_ff) begin
                     single_in = ST_WAIT;
                     state_in  = S_SINGLE;
                  end else begin
                     cursor_in = base_ff;
                     state_in  = S_EMIT;
                  end
               end
            end else begin
               retry_in = '0;
               if (!empty_ff) begin
                  if (ack_ff > loaded_s) begin
                     // ack beyond every loaded id: drop the window
                     empty_in = 1'b1;
                     base_in  = '0;
                  end else if (ack_ff > base_s) begin
                     base_in = ack_ff[ID_W-1:0];
                  end
               end
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (full || (loaded_ff >= total_ff)) begin
               if (empty_ff) begin
                  single_in = ST_WAIT;
                  state_in  = S_SINGLE;
               end else begin
                  cursor_in = base_ff;
                  state_in  = S_EMIT;
               end
            end else begin
               loaded_in = inc_sum[ID_W-1:0];
               if (empty_ff) begin
                  base_in  = inc_sum[ID_W-1:0];
                  empty_in = 1'b0;
               end
            end
         end
         S_EMIT: begin
            push_valid          = 1'b1;
            push_item.status    = ST_SEND;
            push_item.packet_id = cursor_ff;
            push_item.last      = (cursor_ff == loaded_ff);
            if (out_free) begin
               if (cursor_ff == loaded_ff) begin
                  state_in = S_IDLE;
               end else begin
                  cursor_in = inc_sum[ID_W-1:0];
               end
            end
         end
         S_SINGLE: begin
            push_valid          = 1'b1;
            push_item.status    = single_ff;
            push_item.packet_id = '0;
            push_item.last      = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         total_ff   <= '0;
         base_ff    <= '0;
         empty_ff   <= 1'b1;
         loaded_ff  <= '0;
         retry_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         base_ff    <= base_in;
         empty_ff   <= empty_in;
         loaded_ff  <= loaded_in;
         retry_ff   <= retry_in;
         running_ff <= running_in;
      end
      cmd_ff    <= cmd_in;
      ack_ff    <= ack_in;
      cursor_ff <= cursor_in;
      single_ff <= single_in;
   end

   swsc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/swsc_out_reg.sv @@
// ----------------------------------------------------------------------------
// swsc_out_reg
// Result output register: holds one transaction until the sink takes it.
// ----------------------------------------------------------------------------
module swsc_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  swsc_pkg::rsp_item_type push_item,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // packet_id
   output logic [2:0]            rsp_tuser,   // status
   output logic                  rsp_tlast    // last
);
   import swsc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   rsp_item_type item_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (free) begin
         valid_in = push_valid;
         if (push_valid) begin
            item_in = push_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = item_ff.packet_id;
   assign rsp_tuser  = item_ff.status;
   assign rsp_tlast  = item_ff.last;

endmodule

@@ rtl/swsc_checker.sv @@
// ----------------------------------------------------------------------------
// swsc_checker
// Port-level assertions for the sender window control, bound to the top.
// ----------------------------------------------------------------------------
module swsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import swsc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // packet ids start at one
   a_send_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_SEND) |-> (rsp_tdata != 16'd0))
      else $error("send result with packet id zero");

   // status-only results are single and carry no id
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_SEND) |-> rsp_tlast && (rsp_tdata == 16'd0))
      else $error("malformed status result");

endmodule

bind sliding_window_sender_control swsc_checker u_swsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the go-back-N sender window control. A clocked
// driver feeds request transactions from a backlog and predicts the window
// results of each one as it is accepted; a clocked monitor checks every
// result transaction in order against those predictions.
// ----------------------------------------------------------------------------
module tb;
   import swsc_pkg::*;

   // the command encoding the block does not use
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // quiet cycles allowed after the last result before touching the register
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 36;

   // how the driver chooses the ack value when it presents the request
   typedef enum {ACK_FIXED, ACK_GOOD, ACK_HIGH, ACK_LOW} ack_pick_type;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      ack_pick_type     pick;
      logic [ACK_W-1:0] raw;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [17:0] ack_value, rest zero
   logic [1:0]  req_tuser = '0;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] packet_id
   logic [2:0]  rsp_tuser;        // [2:0] status
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;   // total_packets

   sliding_window_sender_control i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- state
   req_item_type request_backlog[$];
   rsp_item_type pending_results[$];

   // shadow of the window state, updated as each request is accepted
   int tot_pkts    = 0;
   int win_base    = 0;
   bit win_empty   = 1'b1;
   int loaded_id   = 0;
   int fail_run    = 0;
   bit xfer_active = 1'b0;

   bit quiet      = 1'b0;   // no idling on either side once set
   int n_errors   = 0;
   int n_requests = 0;
   int n_results  = 0;
   int n_cfg      = 0;
   int n_aborts   = 0;
   int n_done     = 0;

   // ------------------------------------------------------------ predictor
   function automatic void expect_result(input logic [STAT_W-1:0] st,
                                         input logic [ID_W-1:0] id,
                                         input logic lst);
      rsp_item_type r;
      r.status    = st;
      r.packet_id = id;
      r.last      = lst;
      pending_results.push_back(r);
   endfunction

   // highest id an ack may name: one past the loaded ids while any remain
   function automatic int highest_acceptable();
      return (loaded_id >= tot_pkts) ? loaded_id : loaded_id + 1;
   endfunction

   // top the window up to WINDOW ids, never beyond total_packets
   function automatic void refill_window();
      int held;
      int slots;
      held  = win_empty ? 0 : loaded_id - win_base + 1;
      slots = (held >= WINDOW) ? 0 : WINDOW - held;
      while (slots > 0 && loaded_id < tot_pkts) begin
         loaded_id = (loaded_id + 1) & 16'hFFFF;
         if (win_empty) begin
            win_base  = loaded_id;
            win_empty = 1'b0;
         end
         slots--;
      end
   endfunction

   // whole window goes out again, or one waiting status when it is empty
   function automatic void expect_window();
      int n;
      if (win_empty) begin
         expect_result(ST_WAIT, '0, 1'b1);
      end else begin
         n = loaded_id - win_base + 1;
         for (int k = 0; k < n; k++)
            expect_result(ST_SEND, 16'(win_base + k), k == n - 1);
      end
   endfunction

   function automatic void predict_window_results(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [ACK_W-1:0] ack_in);
      int ack_v;
      int floor_id;
      ack_v = ack_in;
      if (cmd == CMD_START) begin
         // restart from the beginning, running or not
         win_base    = 0;
         win_empty   = 1'b1;
         loaded_id   = 0;
         fail_run    = 0;
         xfer_active = 1'b1;
         refill_window();
         expect_window();
      end else if (cmd == CMD_UNUSED || !xfer_active) begin
         expect_result(ST_IDLE, '0, 1'b1);
      end else if (cmd == CMD_ACK && ack_in == ACK_DONE) begin
         xfer_active = 1'b0;
         fail_run    = 0;
         expect_result(ST_DONE, '0, 1'b1);
      end else begin
         floor_id = win_empty ? 0 : win_base;
         if (cmd == CMD_TIMEOUT || ack_v > highest_acceptable() || ack_v < floor_id) begin
            fail_run++;
            if (fail_run >= MAX_FAILURES) begin
               xfer_active = 1'b0;
               fail_run    = 0;
               expect_result(ST_ABORT, '0, 1'b1);
            end else begin
               expect_window();
            end
         end else begin
            fail_run = 0;
            if (!win_empty) begin
               if (ack_v > loaded_id) begin
                  // beyond every loaded id: empty, then refill past them
                  win_empty = 1'b1;
                  win_base  = 0;
               end else if (ack_v > win_base) begin
                  win_base = ack_v;
               end
            end
            refill_window();
            expect_window();
         end
      end
   endfunction

   // resolve a symbolic ack against the window as it stands right now
   function automatic logic [ACK_W-1:0] pick_ack_value(input req_item_type it);
      int ceiling;
      int floor_id;
      int v;
      ceiling  = highest_acceptable();
      floor_id = win_empty ? 0 : win_base;
      case (it.pick)
         ACK_GOOD: begin
            if ($urandom_range(0, 1) == 0)
               v = ceiling;
            else
               v = $urandom_range(ceiling, floor_id);
         end
         ACK_HIGH: begin
            if ($urandom_range(0, 3) == 0)
               v = $urandom_range(131071, ceiling + 1);
            else
               v = ceiling + 1 + $urandom_range(0, 2);
         end
         ACK_LOW: begin
            if ($urandom_range(0, 5) == 0)
               v = -131072;
            else
               v = floor_id - 1 - $urandom_range(0, 2);
            // -1 would end the transfer rather than fail it
            if (v == -1)
               v = -2;
         end
         default: v = it.raw;
      endcase
      return v[ACK_W-1:0];
   endfunction

   // --------------------------------------------------------------- driver
   // Predicts each accepted request first, so that the next request is
   // resolved against up-to-date window state.
   int gap_left = 0;

   always @(posedge clock) begin : req_driver
      req_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_window_results(req_tuser, req_tdata[ACK_W-1:0]);
            n_requests++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (!quiet && request_backlog.size() > 0 &&
                         $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 2);
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               nxt = request_backlog.pop_front();
               req_tuser  <= nxt.cmd;
               req_tdata  <= {6'b0, pick_ack_value(nxt)};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------- monitor
   int stall_left = 0;

   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (rsp_tuser == ST_ABORT)
               n_aborts++;
            if (rsp_tuser == ST_DONE)
               n_done++;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result: status %0d id %0d last %0b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               n_errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata !== want.packet_id ||
                   rsp_tlast !== want.last) begin
                  $display({"%0t: result mismatch: expected status %0d id %0d last %0b,",
                            " got status %0d id %0d last %0b"},
                           $time, want.status, want.packet_id, want.last,
                           rsp_tuser, rsp_tdata, rsp_tlast);
                  n_errors++;
               end
            end
         end
         // sink back-pressure in short bursts
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------ stimulus
   function automatic void queue_request(input logic [CMD_W-1:0] cmd, input ack_pick_type pick,
                                         input logic [ACK_W-1:0] raw);
      req_item_type it;
      it.cmd  = cmd;
      it.pick = pick;
      it.raw  = raw;
      request_backlog.push_back(it);
   endfunction

   // wait until every request is in and every result out, then let the
   // sequencer settle; checked at the falling edge, clear of the drivers
   task automatic wait_drained();
      do
         @(negedge clock);
      while (request_backlog.size() != 0 || req_tvalid || pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_total(input logic [15:0] value);
      wait_drained();
      @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      tot_pkts = value;
      n_cfg++;
   endtask

   initial begin : stimulus
      int tot;
      int r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // nothing running: everything but a start is ignored
      queue_request(CMD_ACK, ACK_FIXED, 18'd5);
      queue_request(CMD_TIMEOUT, ACK_FIXED, 18'd0);
      queue_request(CMD_UNUSED, ACK_FIXED, 18'h3FFFF);

      // empty file: the window never fills
      write_total(16'd0);
      queue_request(CMD_START, ACK_FIXED, 18'd0);
      queue_request(CMD_ACK, ACK_FIXED, 18'd0);
      queue_request(CMD_TIMEOUT, ACK_FIXED, 18'd0);
      queue_request(CMD_ACK, ACK_FIXED, ACK_DONE);

      // seven packets: slide, failures up to abort, ack past loaded ids
      write_total(16'd7);
      queue_request(CMD_START, ACK_FIXED, 18'd0);
      queue_request(CMD_ACK, ACK_FIXED, 18'd3);
      queue_request(CMD_ACK, ACK_FIXED, 18'h1FFFF);
      queue_request(CMD_ACK, ACK_FIXED, 18'h20000);
      queue_request(CMD_ACK, ACK_FIXED, 18'd2);
      queue_request(CMD_START, ACK_FIXED, 18'd0);
      queue_request(CMD_ACK, ACK_FIXED, 18'd6);
      queue_request(CMD_ACK, ACK_FIXED, 18'd8);
      queue_request(CMD_ACK, ACK_FIXED, 18'd7);
      queue_request(CMD_START, ACK_FIXED, 18'h15555);
      queue_request(CMD_UNUSED, ACK_FIXED, 18'd0);

      // largest file, then the total lowered mid-transfer
      write_total(16'hFFFF);
      queue_request(CMD_START, ACK_FIXED, 18'h2AAAA);
      queue_request(CMD_ACK, ACK_FIXED, 18'd65536);
      queue_request(CMD_ACK, ACK_FIXED, 18'd6);
      queue_request(CMD_ACK, ACK_FIXED, 18'd8);
      write_total(16'd3);
      queue_request(CMD_ACK, ACK_FIXED, 18'd12);
      queue_request(CMD_ACK, ACK_FIXED, ACK_DONE);
      queue_request(CMD_TIMEOUT, ACK_FIXED, 18'd0);

      // random phases: mostly acceptable acks, with failures and noise
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: tot = 1;
            1: tot = 65535;
            2: tot = 12;
            3: tot = 0;
            4: tot = 5;
            5: tot = $urandom_range(65535, 0);
            6: tot = 64;
            default: tot = $urandom_range(9, 2);
         endcase
         write_total(16'(tot));
         if (ph == RANDOM_PHASES - 1)
            quiet = 1'b1;
         // sometimes carry the transfer over into the new total
         if ($urandom_range(0, 3) != 0)
            queue_request(CMD_START, ACK_FIXED, 18'($urandom()));
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
               queue_request(CMD_ACK, ACK_GOOD, '0);
            else if (r < 65)
               queue_request(CMD_TIMEOUT, ACK_FIXED, 18'($urandom()));
            else if (r < 72)
               queue_request(CMD_ACK, ACK_HIGH, '0);
            else if (r < 78)
               queue_request(CMD_ACK, ACK_LOW, '0);
            else if (r < 83)
               queue_request(CMD_ACK, ACK_FIXED, ACK_DONE);
            else if (r < 88)
               queue_request(CMD_START, ACK_FIXED, 18'($urandom()));
            else if (r < 92)
               queue_request(CMD_UNUSED, ACK_FIXED, 18'($urandom()));
            else
               queue_request(2'($urandom_range(3, 0)), ACK_FIXED, 18'($urandom()));
         end
      end

      wait_drained();
      $display("Covered %0d request and %0d result transactions over %0d total_packets writes",
               n_requests, n_results, n_cfg);
      $display("Transfers completed: %0d, aborted after repeated failures: %0d",
               n_done, n_aborts);
      if (n_errors == 0)
         $display("sliding_window_sender_control verification clean");
      else
         $display("sliding_window_sender_control verification failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("sliding_window_sender_control verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/swsc_pkg.sv
rtl/swsc_out_reg.sv
rtl/sliding_window_sender_control.sv
rtl/swsc_checker.sv
tb/sv/tb.sv
